// ===== rtl/rhsl_pkg.sv =====
// Shared types and constants for the RGB to HSL converter.
// Used by rhsl_div_pipe, rgb_to_hsl_converter_top and the testbench; no dependencies.
`timescale 1ns / 1ps

package rhsl_pkg;

  // Input channel width and fixed-point format of saturation and lightness
  localparam int CHAN_W    = 8;
  localparam int FRAC_BITS = 16;
  localparam int FRAC_W    = FRAC_BITS + 1;
  localparam int HUE_W     = 9;

  // Hue numerator reaches 360 * 255, which needs 17 bits
  localparam int HUE_NUM_W = 17;

  // Divider geometry: wide enough for the saturation dividend and the hue numerator
  localparam int NUM_W      = FRAC_BITS + CHAN_W + 1;
  localparam int DEN_W      = CHAN_W + 1;
  localparam int STEP_BITS  = 5;
  localparam int DIV_STAGES = (NUM_W + STEP_BITS - 1) / STEP_BITS;

  // Division lanes
  localparam int LANES      = 2;
  localparam int LANE_HUE   = 0;
  localparam int LANE_SAT   = 1;

  // Lightness (max+min) / 510 as a multiply by a rounded-up reciprocal;
  // a 17-bit shift keeps the floor exact for every sum up to 510
  localparam int LIGHT_SHIFT  = 17;
  localparam int RECIP_W      = FRAC_BITS + LIGHT_SHIFT - CHAN_W;
  localparam int LIGHT_PROD_W = DEN_W + RECIP_W;
  localparam logic [RECIP_W-1:0] LIGHT_RECIP =
    RECIP_W'(((longint'(1) << (FRAC_BITS + LIGHT_SHIFT)) + 509) / 510);

  // Largest legal fraction value
  localparam logic [FRAC_W-1:0] FRAC_ONE  = FRAC_W'(1) << FRAC_BITS;

  typedef logic [NUM_W-1:0] div_num_t;
  typedef logic [DEN_W-1:0] div_den_t;

  // Working state of one division lane
  typedef struct packed {
    logic [DEN_W-1:0] rem;
    div_num_t         acc;
    div_den_t         den;
  } div_lane_t;

endpackage

// ===== rtl/rhsl_div_pipe.sv =====
// Pipelined restoring divider, two unsigned lanes in lockstep plus a lightness sideband.
// Depends on rhsl_pkg for widths, stage count and lane types.
`timescale 1ns / 1ps

module rhsl_div_pipe
  import rhsl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  div_num_t [LANES-1:0]   in_num,
  input  div_den_t [LANES-1:0]   in_den,
  input  logic [FRAC_W-1:0]      in_light,
  output logic                   out_valid,
  input  logic                   out_stall,
  output div_num_t [LANES-1:0]   out_quo,
  output logic [FRAC_W-1:0]      out_light
);

  // One shift-compare-subtract step; the quotient bit shifts into acc
  function automatic div_lane_t lane_step(input div_lane_t s);
    logic [DEN_W:0] t;
    logic           qbit;
    div_lane_t      o;
    t    = {s.rem, s.acc[NUM_W-1]};
    qbit = (t >= {1'b0, s.den});
    o.den = s.den;
    o.rem = qbit ? DEN_W'(t - {1'b0, s.den}) : t[DEN_W-1:0];
    o.acc = {s.acc[NUM_W-2:0], qbit};
    return o;
  endfunction

  logic [DIV_STAGES-1:0] valid_r;
  logic [DIV_STAGES-1:0] en;
  div_lane_t             st_r    [DIV_STAGES][LANES];
  div_lane_t             st_nxt  [DIV_STAGES][LANES];
  logic [FRAC_W-1:0]     light_r [DIV_STAGES];

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    en[DIV_STAGES-1] = !valid_r[DIV_STAGES-1] || !out_stall;
    for (int k = DIV_STAGES - 2; k >= 0; k--) begin
      en[k] = !valid_r[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];

  // Run STEP_BITS division steps per stage; the last stage may run fewer
  always_comb begin
    div_lane_t cur;
    for (int l = 0; l < LANES; l++) begin
      cur.rem = '0;
      cur.acc = in_num[l];
      cur.den = in_den[l];
      for (int j = 0; j < STEP_BITS; j++) begin
        if (j < NUM_W) begin
          cur = lane_step(cur);
        end
      end
      st_nxt[0][l] = cur;
    end
    for (int k = 1; k < DIV_STAGES; k++) begin
      for (int l = 0; l < LANES; l++) begin
        cur = st_r[k-1][l];
        for (int j = 0; j < STEP_BITS; j++) begin
          if (k * STEP_BITS + j < NUM_W) begin
            cur = lane_step(cur);
          end
        end
        st_nxt[k][l] = cur;
      end
    end
  end

  // Move valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (en[0]) begin
        valid_r[0] <= in_valid;
      end
      for (int k = 1; k < DIV_STAGES; k++) begin
        if (en[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  // Hold stage payload while stalled
  always_ff @(posedge clk) begin
    if (en[0]) begin
      light_r[0] <= in_light;
    end
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (en[k]) begin
        for (int l = 0; l < LANES; l++) begin
          st_r[k][l] <= st_nxt[k][l];
        end
      end
    end
    for (int k = 1; k < DIV_STAGES; k++) begin
      if (en[k]) begin
        light_r[k] <= light_r[k-1];
      end
    end
  end

  assign out_valid = valid_r[DIV_STAGES-1];
  assign out_light = light_r[DIV_STAGES-1];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      out_quo[l] = st_r[DIV_STAGES-1][l].acc;
    end
  end

endmodule

// ===== rtl/rgb_to_hsl_converter_top.sv =====
// Top level of the RGB to HSL converter: front stages and output mapping.
// Depends on rhsl_pkg and instantiates rhsl_div_pipe.
`timescale 1ns / 1ps

// Usage:
//   Input channel: in_valid / in_stall with one 8-bit red, green and blue value
//   per transfer. Result channel: out_valid / out_stall with hue in whole degrees
//   (0..359) and saturation and lightness as unsigned Q1.16 (65536 = 1.0).
//   Every pixel gives exactly one result, in order.
//   Throughput: one pixel per clock while out_stall is low. The pipeline has two
//   front stages (max/min, then hue numerator and lightness by reciprocal
//   multiply) and a 25-step restoring divider done 5 steps per stage, hue and
//   saturation quotients in parallel lanes with the lightness carried alongside.
//   The last divider stage is the output register. When the receiver stalls,
//   the result holds and stages fill up bubble by bubble; in_stall rises only
//   once every stage holds a pixel.
//   Reset (rst_n low, synchronous) clears all valid bits; payload registers
//   are not reset.

module rgb_to_hsl_converter_top
  import rhsl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAN_W-1:0] in_red_in,
  input  logic [CHAN_W-1:0] in_green_in,
  input  logic [CHAN_W-1:0] in_blue_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [HUE_W-1:0]  out_hue_deg,
  output logic [FRAC_W-1:0] out_saturation,
  output logic [FRAC_W-1:0] out_lightness
);

  localparam logic [1:0] SEC_RED   = 2'd0;
  localparam logic [1:0] SEC_GREEN = 2'd1;
  localparam logic [1:0] SEC_BLUE  = 2'd2;

  // Stage 1 registers
  logic                s1_valid_r;
  logic [1:0]          s1_sector_r;
  logic signed [CHAN_W:0] s1_diff_r;
  logic [CHAN_W-1:0]   s1_d_r;
  logic [CHAN_W-1:0]   s1_den_r;
  logic [CHAN_W:0]     s1_sum_r;
  logic                s1_grey_r;

  // Stage 1 next values
  logic [CHAN_W-1:0]   mx;
  logic [CHAN_W-1:0]   mn;
  logic [1:0]          s1_sector_nxt;
  logic signed [CHAN_W:0] s1_diff_nxt;
  logic [CHAN_W:0]     s1_sum_nxt;
  logic [CHAN_W:0]     inv_sum;

  // Stage 2 registers and next values
  logic                 s2_valid_r;
  div_num_t [LANES-1:0] s2_num_r;
  div_den_t [LANES-1:0] s2_den_r;
  logic [FRAC_W-1:0]    s2_light_r;
  div_num_t [LANES-1:0] s2_num_nxt;
  div_den_t [LANES-1:0] s2_den_nxt;
  logic [FRAC_W-1:0]    s2_light_nxt;
  logic [LIGHT_PROD_W-1:0] light_prod;
  logic signed [HUE_NUM_W+1:0] d_s;
  logic signed [HUE_NUM_W+1:0] hue_num_s;

  // Handshake between stages
  logic                 s1_en;
  logic                 s2_en;
  logic                 div_stall;
  div_num_t [LANES-1:0] quo;

  assign s2_en    = !s2_valid_r || !div_stall;
  assign s1_en    = !s1_valid_r || s2_en;
  assign in_stall = !s1_en;

  // Find max, min and the hue sector with its channel difference
  always_comb begin
    mx = (in_red_in > in_green_in) ? in_red_in : in_green_in;
    mx = (mx > in_blue_in) ? mx : in_blue_in;
    mn = (in_red_in < in_green_in) ? in_red_in : in_green_in;
    mn = (mn < in_blue_in) ? mn : in_blue_in;
    s1_sum_nxt = {1'b0, mx} + {1'b0, mn};
    inv_sum    = (CHAN_W+1)'(510) - s1_sum_nxt;
    priority if (in_red_in == mx) begin
      s1_sector_nxt = SEC_RED;
      s1_diff_nxt   = $signed({1'b0, in_green_in}) - $signed({1'b0, in_blue_in});
    end else if (in_green_in == mx) begin
      s1_sector_nxt = SEC_GREEN;
      s1_diff_nxt   = $signed({1'b0, in_blue_in}) - $signed({1'b0, in_red_in});
    end else begin
      s1_sector_nxt = SEC_BLUE;
      s1_diff_nxt   = $signed({1'b0, in_red_in}) - $signed({1'b0, in_green_in});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_sector_r <= s1_sector_nxt;
      s1_diff_r   <= s1_diff_nxt;
      s1_d_r      <= mx - mn;
      s1_sum_r    <= s1_sum_nxt;
      s1_den_r    <= (s1_sum_nxt <= (CHAN_W+1)'(255)) ? s1_sum_nxt[CHAN_W-1:0]
                                                      : inv_sum[CHAN_W-1:0];
      s1_grey_r   <= (mx == mn);
    end
  end

  // Build hue numerator in 0..360*d, the two dividend/divisor pairs and lightness
  always_comb begin
    d_s = $signed({{(HUE_NUM_W+2-CHAN_W){1'b0}}, s1_d_r});
    unique case (s1_sector_r)
      SEC_RED:   hue_num_s = '0;
      SEC_GREEN: hue_num_s = d_s * (HUE_NUM_W+2)'(120);
      SEC_BLUE:  hue_num_s = d_s * (HUE_NUM_W+2)'(240);
      default:   hue_num_s = '0;
    endcase
    hue_num_s = hue_num_s
              + (HUE_NUM_W+2)'(s1_diff_r) * $signed((HUE_NUM_W+2)'(60));
    if (s1_sector_r == SEC_RED && hue_num_s < 0) begin
      hue_num_s = hue_num_s + d_s * (HUE_NUM_W+2)'(360);
    end

    // Grey pixel: divide zero by one so hue and saturation come out zero
    if (s1_grey_r) begin
      s2_num_nxt[LANE_HUE] = '0;
      s2_den_nxt[LANE_HUE] = DEN_W'(1);
      s2_num_nxt[LANE_SAT] = '0;
      s2_den_nxt[LANE_SAT] = DEN_W'(1);
    end else begin
      s2_num_nxt[LANE_HUE] = NUM_W'(hue_num_s[HUE_NUM_W-1:0]);
      s2_den_nxt[LANE_HUE] = DEN_W'(s1_d_r);
      s2_num_nxt[LANE_SAT] = NUM_W'({s1_d_r, {FRAC_BITS{1'b0}}});
      s2_den_nxt[LANE_SAT] = DEN_W'(s1_den_r);
    end

    // Lightness: multiply the channel sum by the reciprocal of 510, then floor
    light_prod   = LIGHT_PROD_W'(s1_sum_r) * LIGHT_PROD_W'(LIGHT_RECIP);
    s2_light_nxt = light_prod[LIGHT_SHIFT +: FRAC_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_num_r   <= s2_num_nxt;
      s2_den_r   <= s2_den_nxt;
      s2_light_r <= s2_light_nxt;
    end
  end

  // Divide both lanes; the last divider stage drives the outputs
  rhsl_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid_r),
    .in_stall  (div_stall),
    .in_num    (s2_num_r),
    .in_den    (s2_den_r),
    .in_light  (s2_light_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_quo   (quo),
    .out_light (out_lightness)
  );

  assign out_hue_deg    = quo[LANE_HUE][HUE_W-1:0];
  assign out_saturation = quo[LANE_SAT][FRAC_W-1:0];

  // Hue stays below a full turn
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hue_deg < HUE_W'(360)))
    else $error("hue out of range");

  // Fractions never exceed 1.0 and upper quotient bits stay clear
  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_saturation <= FRAC_ONE && quo[LANE_SAT] <= NUM_W'(FRAC_ONE)))
    else $error("saturation out of range");

  a_light_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_lightness <= FRAC_ONE))
    else $error("lightness out of range");

  // Input backpressure only comes from a full pipe behind a stalled output
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && s1_valid_r && s2_valid_r))
    else $error("input stalled without output backpressure");

endmodule

// ===== tb/rgb_to_hsl_converter_top_tb.sv =====
// Self-checking testbench for rgb_to_hsl_converter_top: directed and random pixels.
// Depends on rhsl_pkg and the RTL; a small scoreboard predicts hue, saturation, lightness.
`timescale 1ns / 1ps

module rgb_to_hsl_converter_top_tb;
  import rhsl_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 4;
  localparam int RANDOM_ITEMS = 2000;
  localparam int PHASES       = 4;
  localparam int DRAIN_CYCLES = 20;
  localparam int WATCHDOG_MAX = 3000;

  typedef logic [CHAN_W-1:0] chan_t;

  // One pixel and the hue, saturation and lightness it should produce
  typedef struct packed {
    chan_t             red;
    chan_t             green;
    chan_t             blue;
    logic [HUE_W-1:0]  hue;
    logic [FRAC_W-1:0] sat;
    logic [FRAC_W-1:0] light;
  } hsl_expect_t;

  class hsl_scoreboard;
    hsl_expect_t hsl_pending[$];
    int          mismatch_count = 0;

    task report(input string what);
      $display("mismatch: %s", what);
      mismatch_count++;
    endtask

    // Exact HSL of one pixel, all quotients floored
    function hsl_expect_t hsl_of_pixel(input chan_t r, input chan_t g, input chan_t b);
      int          ir, ig, ib, mx, mn, sum, d, den, num;
      hsl_expect_t res;
      ir = int'(r);
      ig = int'(g);
      ib = int'(b);
      mx = (ir > ig) ? ir : ig;
      mx = (mx > ib) ? mx : ib;
      mn = (ir < ig) ? ir : ig;
      mn = (mn < ib) ? mn : ib;
      sum = mx + mn;
      res.red   = r;
      res.green = g;
      res.blue  = b;
      res.light = FRAC_W'((longint'(sum) << FRAC_BITS) / 510);
      res.sat   = '0;
      res.hue   = '0;
      if (mx != mn) begin
        d   = mx - mn;
        den = (sum <= 255) ? sum : (510 - sum);
        res.sat = FRAC_W'((longint'(d) << FRAC_BITS) / den);
        // sector picked by the first channel equal to the max
        if (ir == mx) begin
          num = 60 * (ig - ib);
          if (num < 0) num += 360 * d;
        end else if (ig == mx) begin
          num = 120 * d + 60 * (ib - ir);
        end else begin
          num = 240 * d + 60 * (ir - ig);
        end
        res.hue = HUE_W'(num / d);
      end
      return res;
    endfunction

    function void note_pixel(input chan_t r, input chan_t g, input chan_t b);
      hsl_pending.push_back(hsl_of_pixel(r, g, b));
    endfunction

    function int pending();
      return hsl_pending.size();
    endfunction

    task check_result(input logic [HUE_W-1:0] hue, input logic [FRAC_W-1:0] sat,
                      input logic [FRAC_W-1:0] light);
      hsl_expect_t exp;
      if (hsl_pending.size() == 0) begin
        report($sformatf("result with no pixel pending: hue %0d sat %0d light %0d",
                         hue, sat, light));
      end else begin
        exp = hsl_pending.pop_front();
        if (hue !== exp.hue)
          report($sformatf("rgb %0d,%0d,%0d hue %0d, want %0d",
                           exp.red, exp.green, exp.blue, hue, exp.hue));
        if (sat !== exp.sat)
          report($sformatf("rgb %0d,%0d,%0d saturation %0d, want %0d",
                           exp.red, exp.green, exp.blue, sat, exp.sat));
        if (light !== exp.light)
          report($sformatf("rgb %0d,%0d,%0d lightness %0d, want %0d",
                           exp.red, exp.green, exp.blue, light, exp.light));
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  chan_t             in_red_in;
  chan_t             in_green_in;
  chan_t             in_blue_in;
  logic              out_valid;
  logic              out_stall;
  logic [HUE_W-1:0]  out_hue_deg;
  logic [FRAC_W-1:0] out_saturation;
  logic [FRAC_W-1:0] out_lightness;

  hsl_scoreboard sb = new();
  bit            gaps_on;
  bit            stalls_on;
  int            idle_cycles = 0;

  rgb_to_hsl_converter_top u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hue_deg   (out_hue_deg),
    .out_saturation(out_saturation),
    .out_lightness (out_lightness)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Mostly short runs, now and then a long one
  function automatic int pick_run_length();
    if ($urandom_range(0, 19) < 16) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: check each transfer, then decide the next stall
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_result(out_hue_deg, out_saturation, out_lightness);
      if (stall_left == 0 && stalls_on && $urandom_range(0, 3) == 0)
        stall_left = pick_run_length();
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Offer one pixel after an optional gap and hold it until the transfer
  task send_pixel(input chan_t r, input chan_t g, input chan_t b);
    int gap;
    gap = (gaps_on && $urandom_range(0, 2) == 0) ? pick_run_length() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_red_in   <= r;
    in_green_in <= g;
    in_blue_in  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_pixel(r, g, b);
  endtask

  // Random pixel biased toward grey, zero or full channels, ties and extremes
  task make_pixel(output chan_t r, output chan_t g, output chan_t b);
    chan_t v;
    r = chan_t'($urandom);
    g = chan_t'($urandom);
    b = chan_t'($urandom);
    v = chan_t'($urandom);
    case ($urandom_range(0, 9))
      4: begin
        g = r;
        b = r;
      end
      5: begin
        case ($urandom_range(0, 2))
          0: r = '0;
          1: g = '0;
          default: b = '0;
        endcase
      end
      6: begin
        case ($urandom_range(0, 2))
          0: r = '1;
          1: g = '1;
          default: b = '1;
        endcase
      end
      7: begin
        case ($urandom_range(0, 2))
          0: g = r;
          1: b = g;
          default: r = b;
        endcase
      end
      8: begin
        r = chan_t'($urandom_range(0, 3));
        g = chan_t'($urandom_range(0, 3));
        b = chan_t'($urandom_range(0, 3));
      end
      9: begin
        r = chan_t'($urandom_range(252, 255));
        g = chan_t'($urandom_range(252, 255));
        b = v | 8'hf0;
      end
      default: ;
    endcase
  endtask

  initial begin
    chan_t r, g, b;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_red_in   <= '0;
    in_green_in <= '0;
    in_blue_in  <= '0;
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: greys, pure hues, sector ties, negative red hue, denominator edges
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd1);
    send_pixel(8'd200, 8'd200, 8'd50);
    send_pixel(8'd10,  8'd200, 8'd200);
    send_pixel(8'd200, 8'd10,  8'd200);
    send_pixel(8'd255, 8'd0,   8'd10);
    send_pixel(8'd200, 8'd55,  8'd100);
    send_pixel(8'd201, 8'd55,  8'd100);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd254, 8'd255, 8'd255);
    send_pixel(8'd1,   8'd1,   8'd0);
    send_pixel(8'd170, 8'd85,  8'd0);
    send_pixel(8'd37,  8'd201, 8'd114);

    // Random phases: no idling, both sides idling, stalls only, gaps only
    for (int phase = 0; phase < PHASES; phase++) begin
      gaps_on   = (phase == 1) || (phase == 3);
      stalls_on = (phase == 1) || (phase == 2);
      for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
        make_pixel(r, g, b);
        send_pixel(r, g, b);
      end
      // hold the input off until the pipeline has drained once
      if (phase == 1) begin
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rhsl_pkg.sv
rtl/rhsl_div_pipe.sv
rtl/rgb_to_hsl_converter_top.sv
tb/rgb_to_hsl_converter_top_tb.sv
